// ===== hw/rtl/clpf_pkg.sv =====
// shared types, constants and helpers for the constrained low-pass pixel filter
package clpf_pkg;

    // configuration register widths and reset values
    localparam int STRENGTH_W = 7;
    localparam int DAMPING_W  = 4;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int MSB_W      = 3;

    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 7'd1;
    localparam logic [DAMPING_W-1:0]  DAMPING_RESET  = 4'd5;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STRENGTH = 1'b0,
        CFG_DAMPING  = 1'b1
    } cfg_index_t;

    // direction codes; the unused code behaves as horizontal only
    localparam int OPCODE_W = 2;
    typedef enum logic [OPCODE_W-1:0] {
        OP_FULL = 2'd0,
        OP_VERT = 2'd1,
        OP_HORZ = 2'd2
    } opcode_t;

    // neighbor order: up_two, up_one, left_two, left_one,
    // right_one, right_two, down_one, down_two
    localparam int NB_COUNT = 8;
    // set bit marks a distance-one neighbor, weighted 3
    localparam logic [NB_COUNT-1:0] NB_WEIGHT3 = 8'b0101_1010;

    // constrained magnitude, weighted magnitude, signed term and sums
    localparam int CMAG_W  = STRENGTH_W;
    localparam int WMAG_W  = CMAG_W + 2;
    localparam int TERM_W  = WMAG_W + 1;
    localparam int DELTA_W = TERM_W + 2;
    localparam int RND_W   = DELTA_W + 1;
    localparam int CORR_W  = DELTA_W - 3;
    localparam int RND_SHIFT = 4;
    localparam int RND_BIAS  = 8;

    // position of the highest set bit, zero for values of zero and one
    function automatic logic [MSB_W-1:0] strength_msb(input logic [STRENGTH_W-1:0] s);
        logic [MSB_W-1:0] r;
        r = '0;
        for (int i = 1; i < STRENGTH_W; i++) begin
            if (s[i]) begin
                r = MSB_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/constrained_lowpass_pixel_filter.sv =====
// constrained low-pass pixel filter: four-stage pipeline, one sample per cycle
// an accepted item passes through the stage 1 to stage 4 registers, then shows on out_valid
// throughput: one item per cycle while out_ready is high; each stage holds one item
// a stage takes a new item when it is empty or its item moves on, so bubbles collapse
// reset (rst_n low, asynchronous) empties the pipeline, strength = 1, damping = 5
// configuration writes act at once; only write with the pipeline empty (not enforced)
module constrained_lowpass_pixel_filter
    import clpf_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] center,
    input  logic [SAMPLE_BITS-1:0] up_two,
    input  logic [SAMPLE_BITS-1:0] up_one,
    input  logic [SAMPLE_BITS-1:0] left_two,
    input  logic [SAMPLE_BITS-1:0] left_one,
    input  logic [SAMPLE_BITS-1:0] right_one,
    input  logic [SAMPLE_BITS-1:0] right_two,
    input  logic [SAMPLE_BITS-1:0] down_one,
    input  logic [SAMPLE_BITS-1:0] down_two,
    input  logic [OPCODE_W-1:0]    opcode,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] filtered
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int RES_W  = SAMPLE_BITS + 2;

    // configuration registers
    logic [STRENGTH_W-1:0] strength_reg;
    logic [DAMPING_W-1:0]  damping_reg;

    // stage handshake
    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    // stage 1 signals
    logic [SAMPLE_BITS-1:0]   raw_nb [NB_COUNT];
    logic [SAMPLE_BITS-1:0]   sel_nb [NB_COUNT];
    logic signed [DIFF_W-1:0] s1_diff [NB_COUNT];
    logic [DIFF_W-1:0]        s1_abs [NB_COUNT];
    logic [SAMPLE_BITS-1:0]   s1_nb_reg [NB_COUNT];
    logic [SAMPLE_BITS-1:0]   s1_mag_reg [NB_COUNT];
    logic [NB_COUNT-1:0]      s1_neg_reg;
    logic [SAMPLE_BITS-1:0]   s1_x_reg;

    // stage 2 signals
    logic [MSB_W-1:0]         str_msb;
    logic [DAMPING_W-1:0]     damp_shift;
    logic [SAMPLE_BITS-1:0]   s2_t [NB_COUNT];
    logic [CMAG_W-1:0]        s2_lim [NB_COUNT];
    logic [CMAG_W-1:0]        s2_cmag [NB_COUNT];
    logic [WMAG_W-1:0]        s2_wmag [NB_COUNT];
    logic signed [TERM_W-1:0] s2_term [NB_COUNT];
    logic [SAMPLE_BITS-1:0]   s2_lo, s2_hi;
    logic signed [TERM_W-1:0] s2_term_reg [NB_COUNT];
    logic [SAMPLE_BITS-1:0]   s2_lo_reg, s2_hi_reg, s2_x_reg;

    // stage 3 signals
    logic signed [DELTA_W-1:0] s3_delta;
    logic signed [DELTA_W-1:0] s3_delta_reg;
    logic [SAMPLE_BITS-1:0]    s3_lo_reg, s3_hi_reg, s3_x_reg;

    // stage 4 signals
    logic signed [RND_W-1:0]  s4_rnd;
    logic signed [CORR_W-1:0] s4_corr;
    logic signed [RES_W-1:0]  s4_res;
    logic [SAMPLE_BITS-1:0]   filtered_next;
    logic [SAMPLE_BITS-1:0]   filtered_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= STRENGTH_RESET;
            damping_reg  <= DAMPING_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STRENGTH: strength_reg <= cfg_data[STRENGTH_W-1:0];
                CFG_DAMPING:  damping_reg  <= cfg_data[DAMPING_W-1:0];
                default:      ;
            endcase
        end
    end

    // a stage loads when empty or when its item moves on
    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: direction select and neighbor differences
    assign raw_nb[0] = up_two;
    assign raw_nb[1] = up_one;
    assign raw_nb[2] = left_two;
    assign raw_nb[3] = left_one;
    assign raw_nb[4] = right_one;
    assign raw_nb[5] = right_two;
    assign raw_nb[6] = down_one;
    assign raw_nb[7] = down_two;

    always_comb
    begin
        sel_nb = raw_nb;
        case (opcode)
            OP_FULL: ;
            OP_VERT:
            begin
                sel_nb[2] = raw_nb[0];
                sel_nb[3] = raw_nb[1];
                sel_nb[4] = raw_nb[6];
                sel_nb[5] = raw_nb[7];
            end
            default:
            begin
                sel_nb[0] = raw_nb[2];
                sel_nb[1] = raw_nb[3];
                sel_nb[6] = raw_nb[4];
                sel_nb[7] = raw_nb[5];
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NB_COUNT; i++)
        begin
            s1_diff[i] = $signed({1'b0, sel_nb[i]}) - $signed({1'b0, center});
            s1_abs[i]  = s1_diff[i][DIFF_W-1] ? DIFF_W'(-s1_diff[i]) : DIFF_W'(s1_diff[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_x_reg <= center;
            for (int i = 0; i < NB_COUNT; i++)
            begin
                s1_nb_reg[i]  <= sel_nb[i];
                s1_mag_reg[i] <= s1_abs[i][SAMPLE_BITS-1:0];
                s1_neg_reg[i] <= s1_diff[i][DIFF_W-1];
            end
        end
    end

    // stage 2: damped constrain, weighting and neighbor span
    assign str_msb    = strength_msb(strength_reg);
    assign damp_shift = (damping_reg > DAMPING_W'(str_msb))
                        ? damping_reg - DAMPING_W'(str_msb) : '0;

    always_comb
    begin
        for (int i = 0; i < NB_COUNT; i++)
        begin
            s2_t[i]   = s1_mag_reg[i] >> damp_shift;
            s2_lim[i] = (SAMPLE_BITS'(strength_reg) > s2_t[i])
                        ? CMAG_W'(SAMPLE_BITS'(strength_reg) - s2_t[i]) : '0;
            s2_cmag[i] = (s1_mag_reg[i] < SAMPLE_BITS'(s2_lim[i]))
                        ? s1_mag_reg[i][CMAG_W-1:0] : s2_lim[i];
            s2_wmag[i] = WMAG_W'(s2_cmag[i])
                        + (NB_WEIGHT3[i] ? WMAG_W'({s2_cmag[i], 1'b0}) : '0);
            s2_term[i] = s1_neg_reg[i] ? -$signed({1'b0, s2_wmag[i]})
                                       : $signed({1'b0, s2_wmag[i]});
        end
    end

    always_comb
    begin
        s2_lo = s1_x_reg;
        s2_hi = s1_x_reg;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            if (s1_nb_reg[i] < s2_lo) s2_lo = s1_nb_reg[i];
            if (s1_nb_reg[i] > s2_hi) s2_hi = s1_nb_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_term_reg <= s2_term;
            s2_lo_reg   <= s2_lo;
            s2_hi_reg   <= s2_hi;
            s2_x_reg    <= s1_x_reg;
        end
    end

    // stage 3: sum of weighted terms
    always_comb
    begin
        s3_delta = '0;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            s3_delta = s3_delta + DELTA_W'(s2_term_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_delta_reg <= s3_delta;
            s3_lo_reg    <= s2_lo_reg;
            s3_hi_reg    <= s2_hi_reg;
            s3_x_reg     <= s2_x_reg;
        end
    end

    // stage 4: symmetric rounding, add to center, clamp to span
    always_comb
    begin
        s4_rnd  = RND_W'(s3_delta_reg) + $signed(RND_W'(RND_BIAS))
                  - $signed(RND_W'(s3_delta_reg[DELTA_W-1]));
        s4_corr = CORR_W'(s4_rnd >>> RND_SHIFT);
        s4_res  = $signed({2'b00, s3_x_reg}) + RES_W'(s4_corr);
        if (s4_res < $signed({2'b00, s3_lo_reg}))
            filtered_next = s3_lo_reg;
        else if (s4_res > $signed({2'b00, s3_hi_reg}))
            filtered_next = s3_hi_reg;
        else
            filtered_next = s4_res[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            filtered_reg <= filtered_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign filtered  = filtered_reg;

    // back-pressure reaches the input only with every stage occupied
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
                       && !out_ready))
        else $error("input stalled with an empty stage");

    // center always lies inside the carried neighbor span
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_lo_reg <= s3_x_reg && s3_x_reg <= s3_hi_reg))
        else $error("neighbor span does not hold the center");

    // an item leaving stage 3 lands in the output register
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s4_ready) |=> s4_valid_reg)
        else $error("item lost between stage 3 and output");

endmodule

// ===== tb/constrained_lowpass_pixel_filter_tb.sv =====
// self-checking testbench for the constrained low-pass pixel filter
module constrained_lowpass_pixel_filter_tb;
    import clpf_pkg::*;

    localparam int SAMPLE_BITS  = 10;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int LATENCY      = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    // unused direction code, behaves as horizontal only
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    // one window around the sample being filtered
    typedef struct {
        logic [SAMPLE_BITS-1:0] center;
        logic [SAMPLE_BITS-1:0] up_two;
        logic [SAMPLE_BITS-1:0] up_one;
        logic [SAMPLE_BITS-1:0] left_two;
        logic [SAMPLE_BITS-1:0] left_one;
        logic [SAMPLE_BITS-1:0] right_one;
        logic [SAMPLE_BITS-1:0] right_two;
        logic [SAMPLE_BITS-1:0] down_one;
        logic [SAMPLE_BITS-1:0] down_two;
        logic [OPCODE_W-1:0]    opcode;
    } window_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] center = '0;
    logic [SAMPLE_BITS-1:0] up_two = '0;
    logic [SAMPLE_BITS-1:0] up_one = '0;
    logic [SAMPLE_BITS-1:0] left_two = '0;
    logic [SAMPLE_BITS-1:0] left_one = '0;
    logic [SAMPLE_BITS-1:0] right_one = '0;
    logic [SAMPLE_BITS-1:0] right_two = '0;
    logic [SAMPLE_BITS-1:0] down_one = '0;
    logic [SAMPLE_BITS-1:0] down_two = '0;
    logic [OPCODE_W-1:0]    opcode = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SAMPLE_BITS-1:0] filtered;

    // mirror of the filter registers
    int strength_setting = int'(STRENGTH_RESET);
    int damping_setting  = int'(DAMPING_RESET);

    logic [SAMPLE_BITS-1:0] expected_filtered[$];
    logic [SAMPLE_BITS-1:0] oldest_filtered;
    int  mismatch_count = 0;
    int  stalled_cycles = 0;
    bit  steady_flow = 1'b0;
    bit  hold_request = 1'b0;

    constrained_lowpass_pixel_filter #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .center(center),
        .up_two(up_two),
        .up_one(up_one),
        .left_two(left_two),
        .left_one(left_one),
        .right_one(right_one),
        .right_two(right_two),
        .down_one(down_one),
        .down_two(down_two),
        .opcode(opcode),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .filtered(filtered)
    );

    always #10 clk = ~clk;

    // damped soft clip of one neighbor difference
    function automatic int constrain_difference(input int diff);
        int mag;
        int top_bit;
        int rest;
        int shift;
        int limit;
        int clipped;
        mag = (diff < 0) ? -diff : diff;
        top_bit = 0;
        rest = strength_setting;
        while (rest > 1)
        begin
            rest = rest >> 1;
            top_bit++;
        end
        shift = (damping_setting > top_bit) ? damping_setting - top_bit : 0;
        limit = strength_setting - (mag >> shift);
        if (limit < 0)
        begin
            limit = 0;
        end
        clipped = (mag < limit) ? mag : limit;
        return (diff < 0) ? -clipped : clipped;
    endfunction

    // filtered sample for one window under the current registers
    function automatic logic [SAMPLE_BITS-1:0] predict_filtered(input window_t w);
        int nb[8];
        int weight[8];
        int x;
        int delta;
        int lo;
        int hi;
        int res;
        weight = '{1, 3, 1, 3, 3, 1, 3, 1};
        x = w.center;
        nb[0] = w.up_two;
        nb[1] = w.up_one;
        nb[2] = w.left_two;
        nb[3] = w.left_one;
        nb[4] = w.right_one;
        nb[5] = w.right_two;
        nb[6] = w.down_one;
        nb[7] = w.down_two;
        // single-direction modes reuse one axis for both
        if (w.opcode == OP_VERT)
        begin
            nb[2] = nb[0];
            nb[3] = nb[1];
            nb[4] = nb[6];
            nb[5] = nb[7];
        end
        else if (w.opcode != OP_FULL)
        begin
            nb[0] = nb[2];
            nb[1] = nb[3];
            nb[6] = nb[4];
            nb[7] = nb[5];
        end
        delta = 0;
        lo = x;
        hi = x;
        for (int i = 0; i < 8; i++)
        begin
            delta += weight[i] * constrain_difference(nb[i] - x);
            if (nb[i] < lo) lo = nb[i];
            if (nb[i] > hi) hi = nb[i];
        end
        // symmetric rounding, arithmetic shift
        res = x + ((8 + delta - ((delta < 0) ? 1 : 0)) >>> 4);
        if (res < lo) res = lo;
        if (res > hi) res = hi;
        return SAMPLE_BITS'(res);
    endfunction

    // window with one value on the vertical arm and one on the horizontal arm
    function automatic window_t cross_window(input int c, input int v, input int h,
                                             input logic [OPCODE_W-1:0] op);
        window_t w;
        w.center    = SAMPLE_BITS'(c);
        w.up_two    = SAMPLE_BITS'(v);
        w.up_one    = SAMPLE_BITS'(v);
        w.down_one  = SAMPLE_BITS'(v);
        w.down_two  = SAMPLE_BITS'(v);
        w.left_two  = SAMPLE_BITS'(h);
        w.left_one  = SAMPLE_BITS'(h);
        w.right_one = SAMPLE_BITS'(h);
        w.right_two = SAMPLE_BITS'(h);
        w.opcode    = op;
        return w;
    endfunction

    // sample within span of the center, clipped to the sample range
    function automatic logic [SAMPLE_BITS-1:0] near_sample(input int c, input int span);
        int v;
        if (span > SAMPLE_MAX)
        begin
            return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        end
        v = c + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return SAMPLE_BITS'(v);
    endfunction

    // mostly smooth windows so the clipping matters, some fully random
    function automatic window_t random_window();
        window_t w;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        w.center = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        if (kind == 0) w.center = '0;
        if (kind == 1) w.center = SAMPLE_BITS'(SAMPLE_MAX);
        span = (kind < 4) ? SAMPLE_MAX + 1 : 3 << (2 * $urandom_range(0, 3));
        w.up_two    = near_sample(w.center, span);
        w.up_one    = near_sample(w.center, span);
        w.left_two  = near_sample(w.center, span);
        w.left_one  = near_sample(w.center, span);
        w.right_one = near_sample(w.center, span);
        w.right_two = near_sample(w.center, span);
        w.down_one  = near_sample(w.center, span);
        w.down_two  = near_sample(w.center, span);
        w.opcode    = OPCODE_W'($urandom_range(0, 3));
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // offer one item, record its expected result once accepted
    task automatic send_window(input window_t w);
        if (!steady_flow && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        center    <= w.center;
        up_two    <= w.up_two;
        up_one    <= w.up_one;
        left_two  <= w.left_two;
        left_one  <= w.left_one;
        right_one <= w.right_one;
        right_two <= w.right_two;
        down_one  <= w.down_one;
        down_two  <= w.down_two;
        opcode    <= w.opcode;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected_filtered.push_back(predict_filtered(w));
    endtask

    // stop offering and wait until every result is back
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        while (expected_filtered.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_STRENGTH)
        begin
            strength_setting = value & ((1 << STRENGTH_W) - 1);
        end
        else
        begin
            damping_setting = value & ((1 << DAMPING_W) - 1);
        end
        @(posedge clk);
    endtask

    task automatic set_filter(input int strength, input int damping);
        settle_pipeline();
        write_register(CFG_STRENGTH, strength);
        write_register(CFG_DAMPING, damping);
    endtask

    task automatic run_random_phase(input int strength, input int damping, input int count);
        set_filter(strength, damping);
        repeat (count) send_window(random_window());
    endtask

    // flat areas, full-scale edges, every direction, zero strength, negative shift
    task automatic test_directed_cases();
        // reset register values
        send_window(cross_window(0, 0, 0, OP_FULL));
        send_window(cross_window(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, OP_FULL));
        send_window(cross_window(0, SAMPLE_MAX, SAMPLE_MAX, OP_FULL));
        send_window(cross_window(SAMPLE_MAX, 0, 0, OP_VERT));
        send_window(cross_window(512, 515, 509, OP_HORZ));
        send_window(cross_window(512, 515, 509, OP_SPARE));
        send_window(cross_window(512, 515, 509, OP_VERT));
        // zero strength leaves the center alone
        set_filter(0, 7);
        send_window(cross_window(500, 0, SAMPLE_MAX, OP_FULL));
        send_window(cross_window(0, SAMPLE_MAX, SAMPLE_MAX, OP_HORZ));
        // damping below the strength msb
        set_filter(64, 0);
        send_window(cross_window(512, 520, 500, OP_FULL));
        send_window(cross_window(512, 520, 500, OP_VERT));
        send_window(cross_window(512, 520, 500, OP_HORZ));
        send_window(cross_window(300, SAMPLE_MAX, 0, OP_FULL));
        // widest strength and damping
        set_filter((1 << STRENGTH_W) - 1, (1 << DAMPING_W) - 1);
        send_window(cross_window(0, SAMPLE_MAX, SAMPLE_MAX, OP_FULL));
        send_window(cross_window(SAMPLE_MAX, 0, 0, OP_FULL));
        send_window(cross_window(600, 700, 450, OP_VERT));
        send_window(cross_window(600, 700, 450, OP_SPARE));
        send_window(cross_window(600, SAMPLE_MAX, 0, OP_FULL));
    endtask

    task automatic test_random_settings();
        run_random_phase($urandom_range(1, 64), $urandom_range(0, 15), 50);
        run_random_phase($urandom_range(1, 127), $urandom_range(0, 15), 50);
        run_random_phase(1, 0, 50);
        run_random_phase(64, 15, 50);
        run_random_phase(127, 0, 50);
        run_random_phase(0, 9, 50);
        run_random_phase(2, 1, 50);
        run_random_phase(32, 4, 50);
    endtask

    // receiver stalls long enough for the pipeline to fill and back up
    task automatic test_output_holdoff();
        set_filter(16, 6);
        hold_request = 1'b1;
        repeat (60) send_window(random_window());
        settle_pipeline();
    endtask

    // bursts separated by a full drain
    task automatic test_drained_bursts();
        repeat (3)
        begin
            repeat (25) send_window(random_window());
            settle_pipeline();
        end
    endtask

    // back-to-back items with both sides always ready
    task automatic test_full_rate();
        set_filter(8, 3);
        steady_flow = 1'b1;
        repeat (100) send_window(random_window());
        settle_pipeline();
        steady_flow = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_filtered.size() == 0)
            begin
                report_mismatch($sformatf("filtered %0d with nothing expected", filtered));
            end
            else
            begin
                oldest_filtered = expected_filtered.pop_front();
                if (filtered !== oldest_filtered)
                begin
                    report_mismatch($sformatf("filtered %0d, expected %0d",
                                              filtered, oldest_filtered));
                end
            end
        end
    end

    // receiver readiness: random stalls, full rate, or a long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady_flow)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= 26);
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_settings();
        test_output_holdoff();
        test_drained_bursts();
        test_full_rate();
        settle_pipeline();
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== constrained_lowpass_pixel_filter.f =====
hw/rtl/clpf_pkg.sv
hw/rtl/constrained_lowpass_pixel_filter.sv
tb/constrained_lowpass_pixel_filter_tb.sv
